/* rtl/core/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, removable with NO_ASSERTIONS
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`endif

`endif

/* rtl/core/slist_pkg.sv */
// ---------------------------------------------------------------------------
// slist_pkg
// types, constants and sizes shared by the sequential list block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package slist_pkg;

  localparam int CAPACITY = 64;

  localparam int OPC_W  = 2;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int FPOS_W = 6;
  localparam int LEN_W  = 7;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam int GRP    = 8;
  localparam int GIDX_W = $clog2(GRP);
  localparam int NGRP   = (CAPACITY + GRP - 1) / GRP;
  localparam int NG_W   = (NGRP > 1) ? $clog2(NGRP) : 1;

  localparam logic [OPC_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPC_W-1:0] OP_ERASE  = 2'd1;
  localparam logic [OPC_W-1:0] OP_FIND   = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE    = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ENC1,
    S_ENC2,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                    ins;
    logic                    ers;
    logic                    cmp;
    logic [CMP_W-1:0]        pos;
    logic [CMP_W-1:0]        cnt;
    logic signed [VAL_W-1:0] value;
  } cell_ctl_t;

endpackage

/* rtl/core/slist_if.sv */
// ---------------------------------------------------------------------------
// slist_if
// valid/ready channels for requests and responses of the sequential list
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface slist_req_if;
  import slist_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OPC_W-1:0]        opcode;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, opcode, position, value, input ready);
  modport sink (input valid, opcode, position, value, output ready);
endinterface

interface slist_rsp_if;
  import slist_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [FPOS_W-1:0] found_position;
  logic [LEN_W-1:0]  length;

  modport source (output valid, status, found_position, length, input ready);
  modport sink (input valid, status, found_position, length, output ready);
endinterface

/* rtl/core/sequential_list_insert_erase_find.sv */
// ---------------------------------------------------------------------------
// sequential_list_insert_erase_find
// ordered list of signed words with insert, erase and find
// ---------------------------------------------------------------------------
// The list is a row of CAPACITY cells, each holding one entry and shifting
// into its neighbour on insert or erase. One transaction is worked on at a
// time: insert, erase and the unused opcode go from execute straight to the
// done state, while find first passes through the registered priority
// encoder over the cell match flags. A new request is taken in the cycle
// after the response is handed to the output register, so the block takes
// no new request before it is through with the last; a response not yet
// taken from the output holds the block in done and so holds back the next.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module sequential_list_insert_erase_find (
  input logic   clk,
  input logic   rst,
  slist_req_if.sink   req,
  slist_rsp_if.source rsp
);
  import slist_pkg::*;

  localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

  state_t                  state, state_next;
  logic [CNT_W-1:0]        count, count_next;
  logic [OPC_W-1:0]        cmd_op;
  logic [POS_W-1:0]        cmd_pos;
  logic signed [VAL_W-1:0] cmd_value;
  logic [STAT_W-1:0]       res_status, res_status_next;
  logic                    rsp_valid, rsp_valid_next;
  logic                    load;

  logic [CMP_W-1:0]        pos_ext;
  logic [CMP_W-1:0]        cnt_ext;
  logic                    ins_ok;
  logic                    ers_ok;
  cell_ctl_t               ctl;

  logic signed [VAL_W-1:0] cell_entry [CAPACITY];
  logic [CAPACITY-1:0]     cell_match;
  logic                    found;
  logic [IDX_W-1:0]        found_idx;

  assign pos_ext = CMP_W'(cmd_pos);
  assign cnt_ext = CMP_W'(count);
  assign ins_ok  = (cmd_op == OP_INSERT) && (cnt_ext < CAP_C) && (pos_ext <= cnt_ext);
  assign ers_ok  = (cmd_op == OP_ERASE) && (pos_ext < cnt_ext);

  assign ctl.ins   = (state == S_EXEC) && ins_ok;
  assign ctl.ers   = (state == S_EXEC) && ers_ok;
  assign ctl.cmp   = (state == S_EXEC) && (cmd_op == OP_FIND);
  assign ctl.pos   = pos_ext;
  assign ctl.cnt   = cnt_ext;
  assign ctl.value = cmd_value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_entry;
    logic signed [VAL_W-1:0] right_entry;

    if (i == 0) begin : g_first
      assign left_entry = '0;
    end else begin : g_left
      assign left_entry = cell_entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_right
      assign right_entry = cell_entry[i+1];
    end

    slist_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .idx         (IDX_W'(i)),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (cell_entry[i]),
      .match       (cell_match[i])
    );
  end

  slist_find u_find (
    .clk       (clk),
    .match     (cell_match),
    .found     (found),
    .found_idx (found_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      rsp_valid  <= 1'b0;
      res_status <= ST_OK;
    end else begin
      state      <= state_next;
      count      <= count_next;
      rsp_valid  <= rsp_valid_next;
      res_status <= res_status_next;
    end
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    res_status_next = res_status;
    load            = 1'b0;
    req.ready       = 1'b0;
    unique case (state)
      S_IDLE: begin
        req.ready = !rst;
        if (req.valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        res_status_next = ST_OK;
        if (cmd_op == OP_INSERT) begin
          if (cnt_ext >= CAP_C) begin
            res_status_next = ST_FULL;
          end else if (pos_ext > cnt_ext) begin
            res_status_next = ST_RANGE;
          end else begin
            count_next = count + 1'b1;
          end
        end else if (cmd_op == OP_ERASE) begin
          if (ers_ok) begin
            count_next = count - 1'b1;
          end else begin
            res_status_next = ST_RANGE;
          end
        end
        state_next = (cmd_op == OP_FIND) ? S_ENC1 : S_DONE;
      end
      S_ENC1: state_next = S_ENC2;
      S_ENC2: state_next = S_DONE;
      S_DONE: begin
        if (!rsp_valid || rsp.ready) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (load) begin
      rsp_valid_next = 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cmd_op    <= req.opcode;
      cmd_pos   <= req.position;
      cmd_value <= req.value;
    end
    if (load) begin
      rsp.length <= LEN_W'(count);
      if (cmd_op == OP_FIND) begin
        rsp.status         <= found ? ST_OK : ST_NOTFOUND;
        rsp.found_position <= found ? FPOS_W'(found_idx) : '0;
      end else begin
        rsp.status         <= res_status;
        rsp.found_position <= '0;
      end
    end
  end

  assign rsp.valid = rsp_valid;

  // checks
  `ASSERT_ALWAYS(a_count_bound, clk, rst, CMP_W'(count) <= CAP_C, "list length above capacity")
  `ASSERT_IMPLIES(a_count_exec, clk, rst, !$stable(count), $past(state) == S_EXEC, "length changed outside execute")
  `ASSERT_IMPLIES(a_full_len, clk, rst, rsp.valid && rsp.status == ST_FULL, rsp.length == LEN_W'(CAPACITY), "full reported on a list that is not full")
  `ASSERT_IMPLIES(a_nf_pos, clk, rst, rsp.valid && rsp.status == ST_NOTFOUND, rsp.found_position == '0, "not found with nonzero position")

endmodule

/* rtl/core/slist_cell.sv */
// ---------------------------------------------------------------------------
// slist_cell
// one list entry: shifts from either neighbour, loads, and flags a match
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module slist_cell (
  input  logic                             clk,
  input  slist_pkg::cell_ctl_t             ctl,
  input  logic [slist_pkg::IDX_W-1:0]      idx,
  input  logic signed [slist_pkg::VAL_W-1:0] left_entry,
  input  logic signed [slist_pkg::VAL_W-1:0] right_entry,
  output logic signed [slist_pkg::VAL_W-1:0] entry,
  output logic                             match
);
  import slist_pkg::*;

  logic [CMP_W-1:0] idx_ext;

  assign idx_ext = CMP_W'(idx);

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (idx_ext > ctl.pos) begin
        entry <= left_entry;
      end else if (idx_ext == ctl.pos) begin
        entry <= ctl.value;
      end
    end else if (ctl.ers && (idx_ext >= ctl.pos)) begin
      entry <= right_entry;
    end
    if (ctl.cmp) begin
      match <= (entry == ctl.value) && (idx_ext < ctl.cnt);
    end
  end

endmodule

/* rtl/core/slist_find.sv */
// ---------------------------------------------------------------------------
// slist_find
// two-stage registered priority encoder over the cell match flags
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module slist_find (
  input  logic                          clk,
  input  logic [slist_pkg::CAPACITY-1:0] match,
  output logic                          found,
  output logic [slist_pkg::IDX_W-1:0]   found_idx
);
  import slist_pkg::*;

  logic [NGRP*GRP-1:0] match_pad;
  logic [NGRP-1:0]     grp_any_c;
  logic [GIDX_W-1:0]   grp_idx_c [NGRP];
  logic [NGRP-1:0]     grp_any;
  logic [GIDX_W-1:0]   grp_idx [NGRP];
  logic [NG_W-1:0]     sel_c;
  logic                found_c;

  assign match_pad = (NGRP*GRP)'(match);

  // lowest set flag inside each group
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_any_c[g] = |match_pad[g*GRP +: GRP];
      grp_idx_c[g] = '0;
      for (int j = GRP - 1; j >= 0; j--) begin
        if (match_pad[g*GRP + j]) begin
          grp_idx_c[g] = GIDX_W'(j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_any <= grp_any_c;
    for (int g = 0; g < NGRP; g++) begin
      grp_idx[g] <= grp_idx_c[g];
    end
  end

  // lowest group holding a flag
  always_comb begin
    sel_c   = '0;
    found_c = |grp_any;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        sel_c = NG_W'(g);
      end
    end
  end

  always_ff @(posedge clk) begin
    found     <= found_c;
    found_idx <= IDX_W'({sel_c, grp_idx[sel_c]});
  end

endmodule
